/* rtl/core/mee_pkg.sv */
`timescale 1ns / 1ps

package mee_pkg;

  typedef enum logic [2:0] {
    KIND_CHECK_IRQ  = 3'd0,
    KIND_ADDR_ERR   = 3'd1,
    KIND_BREAK      = 3'd2,
    KIND_COP_UNUSE  = 3'd3,
    KIND_IRQ        = 3'd4,
    KIND_TLB_MISS   = 3'd5,
    KIND_SYSCALL    = 3'd6
  } kind_e;

  // ExcCode values
  localparam logic [4:0] EXC_INT  = 5'd0;
  localparam logic [4:0] EXC_TLBL = 5'd2;
  localparam logic [4:0] EXC_ADEL = 5'd4;
  localparam logic [4:0] EXC_ADES = 5'd5;
  localparam logic [4:0] EXC_SYS  = 5'd8;
  localparam logic [4:0] EXC_BP   = 5'd9;
  localparam logic [4:0] EXC_CPU  = 5'd11;

  localparam logic [31:0] VEC_GENERAL = 32'h8000_0180;
  localparam logic [31:0] VEC_REFILL  = 32'h8000_0000;
  localparam logic [31:0] CTX_KEEP    = 32'hFF80_000F;
  localparam logic [31:0] CTX_VPN     = 32'h007F_FFF0;
  localparam logic [31:0] EHI_MASK    = 32'hFFFF_E000;
  localparam logic [31:0] CE_ONE      = 32'h1000_0000;
  localparam logic [31:0] CAUSE_CLR   = 32'hB000_007C; // BD, CE, ExcCode
  localparam logic [31:0] CAUSE_CE_EXC = 32'h3000_007C;
  localparam logic [31:0] ST_IM       = 32'h0000_FF00;
  localparam logic [2:0]  ST_IE_ONLY  = 3'b001;       // IE=1, EXL=0, ERL=0
  localparam int unsigned IP2_POS     = 10;
  localparam int unsigned BD_POS      = 31;
  localparam int unsigned ST_EXL      = 1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] fault_address;
    logic        fetch_side;
    logic [1:0]  cop_index;
    logic        in_slot;
    logic [31:0] pc_in;
    logic [31:0] status_in;
    logic [31:0] cause_in;
    logic [31:0] context_in;
    logic [5:0]  mi_pending;
    logic [5:0]  mi_enable;
    logic        address_mapped;
  } entry_in_t;

  typedef struct packed {
    logic [31:0] cause_out;
    logic [31:0] status_out;
    logic [31:0] epc_out;
    logic        epc_write;
    logic [31:0] badvaddr_out;
    logic        badvaddr_write;
    logic [31:0] context_out;
    logic [31:0] entryhi_out;
    logic        entryhi_write;
    logic [31:0] pc_out;
    logic        irq_found;
  } entry_out_t;

endpackage

/* rtl/core/mips_exception_entry.sv */
`timescale 1ns / 1ps

// Coprocessor-0 exception entry.
//
// Command channel: drive item_i and pulse start for one cycle; the item is
// taken at any clock edge where start is high and busy is low. busy never
// rises, so one item can be taken on every clock.
// Result channel: result_o is shown for exactly one cycle, flagged by
// result_valid_o, from the edge after the one that took the item; the item
// passes through the input register and then the result register. The
// receiver cannot hold results off and must take each one in the cycle it is
// shown.
// Throughput: one item per cycle; the only logic between the two registers
// is the field update, a 32-bit decrement for EPC and the vector select.
// Reset (rst_ni low, asynchronous) clears both valid flags, so nothing in
// flight is reported; the payload registers are not reset.
// Events: interrupt check updates Cause.IP2 and reports a takeable interrupt;
// the other kinds (an interrupt only if IE-only) enter an exception, writing
// ExcCode, BD, Status.EXL, EPC and the vector. A TLB miss with EXL already set
// only updates the code fields, BadVAddr, Context and EntryHi and redirects to
// the general vector. An unused kind passes everything through untouched.
module mips_exception_entry
  import mee_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  entry_in_t  item_i,
  output logic       result_valid_o,
  output entry_out_t result_o
);

  logic       in_vld_q;
  entry_in_t  in_q;
  logic       res_vld_q;
  entry_out_t res_q;
  entry_out_t res_d;

  assign busy = 1'b0;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= item_i;
    end
  end

  // Exception decode and field update
  always_comb begin
    logic [31:0] cause;
    logic [31:0] st;
    logic [31:0] ctx;
    logic [4:0]  code;
    logic [31:0] ce;
    logic        take;
    logic        ie_only;

    cause   = in_q.cause_in;
    st      = in_q.status_in;
    ctx     = in_q.context_in;
    code    = EXC_INT;
    ce      = '0;
    take    = 1'b0;
    ie_only = (in_q.status_in[2:0] == ST_IE_ONLY);

    res_d                    = '0;
    res_d.pc_out             = in_q.pc_in;

    case (in_q.kind)
      KIND_CHECK_IRQ: begin
        cause[IP2_POS]  = |(in_q.mi_pending & in_q.mi_enable);
        res_d.irq_found = (|(cause & st & ST_IM)) && ie_only;
      end
      KIND_ADDR_ERR: begin
        code                 = in_q.fetch_side ? EXC_ADEL : EXC_ADES;
        res_d.badvaddr_out   = in_q.fault_address;
        res_d.badvaddr_write = 1'b1;
        take                 = 1'b1;
      end
      KIND_BREAK: begin
        code = EXC_BP;
        take = 1'b1;
      end
      KIND_COP_UNUSE: begin
        code = EXC_CPU;
        ce   = (in_q.cop_index == 2'd1) ? CE_ONE : '0;
        take = 1'b1;
      end
      KIND_IRQ: begin
        take = ie_only;
      end
      KIND_TLB_MISS: begin
        res_d.badvaddr_out   = in_q.fault_address;
        res_d.badvaddr_write = 1'b1;
        res_d.entryhi_out    = in_q.fault_address & EHI_MASK;
        res_d.entryhi_write  = 1'b1;
        ctx = (ctx & CTX_KEEP) | ({9'd0, in_q.fault_address[31:9]} & CTX_VPN);
        if (st[ST_EXL]) begin
          // nested miss: Cause code fields only, BD and Status kept
          cause        = (cause & ~CAUSE_CE_EXC) | {25'd0, EXC_TLBL, 2'b00};
          res_d.pc_out = VEC_GENERAL;
        end else begin
          code = EXC_TLBL;
          take = 1'b1;
        end
      end
      KIND_SYSCALL: begin
        code = EXC_SYS;
        take = 1'b1;
      end
      default: begin
      end
    endcase

    if (take) begin
      cause            = (cause & ~CAUSE_CLR) | {25'd0, code, 2'b00} | ce;
      cause[BD_POS]    = in_q.in_slot;
      res_d.epc_out    = in_q.in_slot ? (in_q.pc_in - 32'd4) : in_q.pc_in;
      res_d.epc_write  = 1'b1;
      st[ST_EXL]       = 1'b1;
      res_d.pc_out     = (in_q.kind == KIND_TLB_MISS && !in_q.address_mapped)
                         ? VEC_REFILL : VEC_GENERAL;
    end

    res_d.cause_out   = cause;
    res_d.status_out  = st;
    res_d.context_out = ctx;
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 result_valid_o)
    else $error("taken item produced no result two cycles later");

  a_epc_sets_exl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.epc_write |-> result_o.status_out[ST_EXL])
    else $error("exception entry without Status.EXL");

  a_ehi_with_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.entryhi_write |-> result_o.badvaddr_write)
    else $error("EntryHi written without BadVAddr");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.badvaddr_write |-> result_o.badvaddr_out == '0)
    else $error("BadVAddr nonzero without write");
`endif

endmodule

/* tb/mee_entry_checker.sv */
`timescale 1ns / 1ps

// Watches the command and result channels of the exception-entry block,
// predicts each result from the accepted item and compares field by field.
module mee_entry_checker
  import mee_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  entry_in_t  item_i,
  input  logic       result_valid_i,
  input  entry_out_t result_i,
  output int         n_fail_o,
  output int         n_pending_o
);

  entry_out_t entry_expected_q[$];

  initial begin
    n_fail_o    = 0;
    n_pending_o = 0;
  end

  // Cause with ExcCode, CE and BD rewritten for a taken exception
  function automatic logic [31:0] enter_cause(input logic [31:0] cause,
                                              input logic [4:0]  code,
                                              input logic [31:0] ce,
                                              input logic        slot);
    logic [31:0] c;
    c = (cause & ~CAUSE_CLR) | ({27'b0, code} << 2) | ce;
    c[BD_POS] = slot;
    return c;
  endfunction

  function automatic entry_out_t predict_entry(input entry_in_t it);
    entry_out_t  r;
    logic [31:0] cause;
    logic [31:0] st;
    logic [4:0]  code;
    logic [31:0] ce;
    logic        take;
    r     = '0;
    cause = it.cause_in;
    st    = it.status_in;
    code  = EXC_INT;
    ce    = '0;
    take  = 1'b0;
    r.context_out = it.context_in;
    r.pc_out      = it.pc_in;
    case (it.kind)
      KIND_CHECK_IRQ: begin
        cause[IP2_POS] = |(it.mi_pending & it.mi_enable);
        r.irq_found = ((cause & st & ST_IM) != '0) && (st[2:0] == ST_IE_ONLY);
      end
      KIND_ADDR_ERR: begin
        code = it.fetch_side ? EXC_ADEL : EXC_ADES;
        r.badvaddr_out   = it.fault_address;
        r.badvaddr_write = 1'b1;
        take = 1'b1;
      end
      KIND_BREAK: begin
        code = EXC_BP;
        take = 1'b1;
      end
      KIND_COP_UNUSE: begin
        code = EXC_CPU;
        ce   = (it.cop_index == 2'd1) ? CE_ONE : '0;
        take = 1'b1;
      end
      KIND_IRQ: begin
        if (st[2:0] == ST_IE_ONLY) begin
          code = EXC_INT;
          take = 1'b1;
        end
      end
      KIND_TLB_MISS: begin
        r.badvaddr_out   = it.fault_address;
        r.badvaddr_write = 1'b1;
        r.entryhi_out    = it.fault_address & EHI_MASK;
        r.entryhi_write  = 1'b1;
        r.context_out    = (it.context_in & CTX_KEEP) | ((it.fault_address >> 9) & CTX_VPN);
        if (st[ST_EXL]) begin
          // nested miss: of Cause only the code fields move, EPC and BD stay
          cause    = (cause & ~CAUSE_CE_EXC) | ({27'b0, EXC_TLBL} << 2);
          r.pc_out = VEC_GENERAL;
        end else begin
          code = EXC_TLBL;
          take = 1'b1;
        end
      end
      KIND_SYSCALL: begin
        code = EXC_SYS;
        take = 1'b1;
      end
      default: ;
    endcase
    if (take) begin
      cause       = enter_cause(cause, code, ce, it.in_slot);
      r.epc_out   = it.in_slot ? it.pc_in - 32'd4 : it.pc_in;
      r.epc_write = 1'b1;
      st[ST_EXL]  = 1'b1;
      r.pc_out    = (it.kind == KIND_TLB_MISS && !it.address_mapped) ? VEC_REFILL
                                                                      : VEC_GENERAL;
    end
    r.cause_out  = cause;
    r.status_out = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    n_fail_o = n_fail_o + 1;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    entry_out_t want;
    if (rst_ni) begin
      if (result_valid_i === 1'b1) begin
        if (entry_expected_q.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          want = entry_expected_q.pop_front();
          check_field("cause_out", result_i.cause_out, want.cause_out);
          check_field("status_out", result_i.status_out, want.status_out);
          check_field("epc_out", result_i.epc_out, want.epc_out);
          check_field("epc_write", 32'(result_i.epc_write), 32'(want.epc_write));
          check_field("badvaddr_out", result_i.badvaddr_out, want.badvaddr_out);
          check_field("badvaddr_write", 32'(result_i.badvaddr_write),
                      32'(want.badvaddr_write));
          check_field("context_out", result_i.context_out, want.context_out);
          check_field("entryhi_out", result_i.entryhi_out, want.entryhi_out);
          check_field("entryhi_write", 32'(result_i.entryhi_write),
                      32'(want.entryhi_write));
          check_field("pc_out", result_i.pc_out, want.pc_out);
          check_field("irq_found", 32'(result_i.irq_found),
                      32'(want.irq_found));
        end
      end
      if (start_i && !busy_i)
        entry_expected_q.push_back(predict_entry(item_i));
    end
    n_pending_o = entry_expected_q.size();
  end

endmodule

/* tb/tb_mips_exception_entry.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the exception-entry block. Prediction and
// comparison live in the checker instantiated beside the DUT.
module tb_mips_exception_entry;
  import mee_pkg::*;

  // Kind code the package leaves unassigned; must pass through untouched
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int         N_RANDOM    = 730;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start  = 1'b0;
  logic       busy;
  entry_in_t  item_i = '0;
  logic       result_valid_o;
  entry_out_t result_o;
  int         n_fail;
  int         n_pending;

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  mips_exception_entry u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  mee_entry_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .n_fail_o       (n_fail),
    .n_pending_o    (n_pending)
  );

  // Random item; status low bits are steered towards IE-only about a
  // third of the time so that interrupts are taken often enough.
  function automatic entry_in_t rand_item();
    entry_in_t it;
    it.kind           = ($urandom_range(15) == 0) ? KIND_UNUSED : 3'($urandom_range(6));
    it.fault_address  = $urandom;
    it.fetch_side     = 1'($urandom);
    it.cop_index      = 2'($urandom);
    it.in_slot        = 1'($urandom);
    it.pc_in          = $urandom;
    it.status_in      = $urandom;
    if ($urandom_range(2) == 0)
      it.status_in[2:0] = ST_IE_ONLY;
    it.cause_in       = $urandom;
    it.context_in     = $urandom;
    it.mi_pending     = 6'($urandom);
    it.mi_enable      = ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom);
    it.address_mapped = 1'($urandom);
    return it;
  endfunction

  // Present one item from a falling edge and hold it until taken.
  // Idle cycles (start low) are inserted first when allowed, ~23 %.
  task automatic send_item(input entry_in_t it, input bit allow_idle);
    @(negedge clk_i);
    if (allow_idle) begin
      while ($urandom_range(99) < 23) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    entry_in_t it;
    int        wait_cycles;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part ---
    // check: enabled pending line, IE only, IM2 on -> detected
    it = rand_item(); it.kind = KIND_CHECK_IRQ;
    it.status_in = 32'h0000_0401; it.cause_in = '0;
    it.mi_pending = 6'h3F; it.mi_enable = 6'h3F;
    send_item(it, 1'b1);
    // check: nothing pending, IP2 set on the way in -> cleared
    it = rand_item(); it.kind = KIND_CHECK_IRQ;
    it.cause_in = 32'hFFFF_FFFF; it.mi_pending = 6'h2A; it.mi_enable = 6'h15;
    send_item(it, 1'b1);
    // check: pending but EXL set -> not takeable
    it = rand_item(); it.kind = KIND_CHECK_IRQ;
    it.status_in = 32'h0000_FF03; it.mi_pending = 6'h01; it.mi_enable = 6'h01;
    send_item(it, 1'b1);
    // address errors: fetch side, then data side in a slot with pc wrapping
    it = rand_item(); it.kind = KIND_ADDR_ERR; it.fetch_side = 1'b1; it.in_slot = 1'b0;
    send_item(it, 1'b1);
    it = rand_item(); it.kind = KIND_ADDR_ERR; it.fetch_side = 1'b0;
    it.in_slot = 1'b1; it.pc_in = '0; it.fault_address = 32'hFFFF_FFFF;
    send_item(it, 1'b1);
    it = rand_item(); it.kind = KIND_BREAK; it.cause_in = 32'hFFFF_FFFF;
    it.in_slot = 1'b0;
    send_item(it, 1'b1);
    // cop unusable: CE set for cop 1 only
    it = rand_item(); it.kind = KIND_COP_UNUSE; it.cop_index = 2'd1; it.cause_in = '0;
    send_item(it, 1'b1);
    it = rand_item(); it.kind = KIND_COP_UNUSE; it.cop_index = 2'd2;
    it.cause_in = 32'hFFFF_FFFF;
    send_item(it, 1'b1);
    it = rand_item(); it.kind = KIND_COP_UNUSE; it.cop_index = 2'd3;
    send_item(it, 1'b1);
    // interrupt, takeable and not
    it = rand_item(); it.kind = KIND_IRQ; it.status_in = 32'h0000_0001;
    send_item(it, 1'b1);
    it = rand_item(); it.kind = KIND_IRQ; it.status_in = 32'hFFFF_FFFF;
    send_item(it, 1'b1);
    // TLB miss: general vector, refill vector, nested under EXL
    it = rand_item(); it.kind = KIND_TLB_MISS; it.status_in = 32'h0000_0000;
    it.address_mapped = 1'b1;
    send_item(it, 1'b1);
    it = rand_item(); it.kind = KIND_TLB_MISS; it.status_in = 32'h0000_0001;
    it.address_mapped = 1'b0; it.fault_address = 32'hFFFF_FFFF;
    send_item(it, 1'b1);
    it = rand_item(); it.kind = KIND_TLB_MISS; it.status_in = 32'h0000_0002;
    it.in_slot = 1'b1; it.address_mapped = 1'b0; it.cause_in = 32'hFFFF_FFFF;
    send_item(it, 1'b1);
    it = rand_item(); it.kind = KIND_SYSCALL;
    send_item(it, 1'b1);
    it = rand_item(); it.kind = KIND_UNUSED;
    send_item(it, 1'b1);
    // all-ones and all-zeros items
    it = '1;
    send_item(it, 1'b1);
    it = '1; it.kind = KIND_TLB_MISS;
    send_item(it, 1'b1);
    it = '0;
    send_item(it, 1'b1);
    it = '0; it.kind = KIND_SYSCALL;
    send_item(it, 1'b1);

    // --- random part ---
    // a block of back-to-back items in the middle, and one full drain
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 500) begin
        @(negedge clk_i);
        start <= 1'b0;
        while (n_pending != 0) @(negedge clk_i);
      end
      send_item(rand_item(), !(i >= 250 && i < 400));
    end

    @(negedge clk_i);
    start <= 1'b0;
    wait_cycles = 0;
    while (n_pending != 0 && wait_cycles < 200) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    // wait on for any stray result before the verdict
    repeat (4) @(negedge clk_i);

    if (n_fail == 0 && n_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
